[rtl/mqsp_pkg.sv]
// ----------------------------------------------------------------------------
// mqsp_pkg
// Shared types and constants for the message queue shared pool block.
// ----------------------------------------------------------------------------
package mqsp_pkg;

   // pool and queue sizing
   localparam int POOL_ENTRIES = 16;
   localparam int NUM_QUEUES   = 4;

   localparam int ENTRY_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int CNT_W   = $clog2(POOL_ENTRIES + 1);
   localparam int QUEUE_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

   // stream payload widths
   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 5;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 2;

   typedef enum logic [1:0] {
      CMD_PUT,
      CMD_GET,
      CMD_REMOVE,
      CMD_FLUSH
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_EMPTY,
      STATUS_FULL,
      STATUS_NOT_FOUND
   } status_type;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_PUT,
      S_RD,
      S_EV,
      S_FREE,
      S_DONE
   } state_type;

   // queue id wraps modulo the number of queues (id is only two bits wide)
   function automatic logic [QUEUE_W-1:0] queue_wrap(input logic [1:0] id);
      logic [4:0] t;
      t = {3'b000, id};
      for (int i = 0; i < 3; i++) begin
         if (t >= 5'(NUM_QUEUES)) begin
            t = t - 5'(NUM_QUEUES);
         end
      end
      return t[QUEUE_W-1:0];
   endfunction

endpackage

[rtl/message_queue_shared_pool.sv]
// ----------------------------------------------------------------------------
// message_queue_shared_pool
// Several linked-list message queues drawing entries from one shared pool.
// ----------------------------------------------------------------------------
// One command is handled at a time and each gives exactly one response
// transaction. After reset the block builds the free list in the link memory
// and takes no request meanwhile. Each step of a get, remove or flush walk
// reads one entry from the entry memories before examining it, and a matched
// entry not at the head takes an extra step to go on the free list. A rejected
// put or a command on an empty queue goes straight to its response. A new
// request can be taken while the previous response still waits on rsp_tready.
module message_queue_shared_pool (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // message_address [31:0], message_size [63:32]
   input  logic [mqsp_pkg::REQ_DATA_W-1:0] req_tdata,
   // command [1:0], queue_id [3:2], put_lifo [4]
   input  logic [mqsp_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // got_address [31:0], got_size [63:32]
   output logic [mqsp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status [1:0]
   output logic [mqsp_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import mqsp_pkg::*;

   // entry memories
   logic [31:0]        addr_mem [POOL_ENTRIES];
   logic [31:0]        len_mem  [POOL_ENTRIES];
   logic [ENTRY_W-1:0] next_mem [POOL_ENTRIES];
   logic [ENTRY_W-1:0] prev_mem [POOL_ENTRIES];

   // memory access controls
   logic               rd_en;
   logic [ENTRY_W-1:0] rd_idx;
   logic               data_we;
   logic [ENTRY_W-1:0] data_wa;
   logic               nx_we;
   logic [ENTRY_W-1:0] nx_wa, nx_wd;
   logic               pv_we;
   logic [ENTRY_W-1:0] pv_wa, pv_wd;

   logic [31:0]        addr_q_ff, len_q_ff;
   logic [ENTRY_W-1:0] next_q_ff, prev_q_ff;

   // control and queue state
   state_type          state_ff, state_in;
   command_type        cmd_ff, cmd_in;
   logic [QUEUE_W-1:0] q_ff, q_in;
   logic [31:0]        maddr_ff, maddr_in;
   logic [31:0]        msize_ff, msize_in;
   logic               lifo_ff, lifo_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic [ENTRY_W-1:0] cur_ff, cur_in;
   logic [ENTRY_W-1:0] nxt_ff, nxt_in;
   logic               found_ff, found_in;
   logic [ENTRY_W-1:0] clr_ff, clr_in;
   logic [ENTRY_W-1:0] free_head_ff, free_head_in;
   logic [CNT_W-1:0]   free_count_ff, free_count_in;
   logic [ENTRY_W-1:0] head_ff [NUM_QUEUES];
   logic [ENTRY_W-1:0] head_in [NUM_QUEUES];
   logic [ENTRY_W-1:0] tail_ff [NUM_QUEUES];
   logic [ENTRY_W-1:0] tail_in [NUM_QUEUES];
   logic [CNT_W-1:0]   count_ff [NUM_QUEUES];
   logic [CNT_W-1:0]   count_in [NUM_QUEUES];
   status_type         res_status_ff, res_status_in;
   logic [31:0]        res_addr_ff, res_addr_in;
   logic [31:0]        res_size_ff, res_size_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [31:0]        rsp_addr_ff, rsp_addr_in;
   logic [31:0]        rsp_size_ff, rsp_size_in;

   // memory ports
   always_ff @(posedge clock) begin
      if (rd_en) begin
         addr_q_ff <= addr_mem[rd_idx];
         len_q_ff  <= len_mem[rd_idx];
         next_q_ff <= next_mem[rd_idx];
         prev_q_ff <= prev_mem[rd_idx];
      end
      if (data_we) begin
         addr_mem[data_wa] <= maddr_ff;
         len_mem[data_wa]  <= msize_ff;
      end
      if (nx_we) begin
         next_mem[nx_wa] <= nx_wd;
      end
      if (pv_we) begin
         prev_mem[pv_wa] <= pv_wd;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         clr_ff        <= '0;
         free_head_ff  <= '0;
         free_count_ff <= CNT_W'(POOL_ENTRIES);
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i]  <= head_in[i];
            tail_ff[i]  <= tail_in[i];
            count_ff[i] <= count_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      q_ff          <= q_in;
      maddr_ff      <= maddr_in;
      msize_ff      <= msize_in;
      lifo_ff       <= lifo_in;
      left_ff       <= left_in;
      cur_ff        <= cur_in;
      nxt_ff        <= nxt_in;
      found_ff      <= found_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_size_ff   <= res_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
   end

   // next state and memory control
   always_comb begin
      logic [QUEUE_W-1:0] qv;
      logic [ENTRY_W-1:0] e, n, p;
      logic               match, is_head, is_tail, do_free, advance;
      logic [CNT_W-1:0]   left_dec;

      state_in      = state_ff;
      cmd_in        = cmd_ff;
      q_in          = q_ff;
      maddr_in      = maddr_ff;
      msize_in      = msize_ff;
      lifo_in       = lifo_ff;
      left_in       = left_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      found_in      = found_ff;
      clr_in        = clr_ff;
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_size_in   = res_size_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_size_in   = rsp_size_ff;

      req_tready = 1'b0;
      rd_en      = 1'b0;
      rd_idx     = cur_ff;
      data_we    = 1'b0;
      data_wa    = free_head_ff;
      nx_we      = 1'b0;
      nx_wa      = cur_ff;
      nx_wd      = free_head_ff;
      pv_we      = 1'b0;
      pv_wa      = cur_ff;
      pv_wd      = cur_ff;

      qv       = queue_wrap(req_tuser[3:2]);
      e        = cur_ff;
      n        = next_q_ff;
      p        = prev_q_ff;
      match    = (cmd_ff != CMD_REMOVE) || (addr_q_ff == maddr_ff);
      is_head  = (cur_ff == head_ff[q_ff]);
      is_tail  = (cur_ff == tail_ff[q_ff]);
      do_free  = 1'b0;
      advance  = 1'b0;
      left_dec = left_ff - 1'b1;

      // response taken downstream
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         // build the free list, one entry a cycle
         S_INIT: begin
            nx_we = 1'b1;
            nx_wa = clr_ff;
            nx_wd = (clr_ff == ENTRY_W'(POOL_ENTRIES - 1)) ? '0 : clr_ff + 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ENTRY_W'(POOL_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end

         // take a request and, unless it is answered at once, start its first memory read
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in      = command_type'(req_tuser[1:0]);
               q_in        = qv;
               lifo_in     = req_tuser[4];
               maddr_in    = req_tdata[31:0];
               msize_in    = req_tdata[63:32];
               found_in    = 1'b0;
               res_addr_in = '0;
               res_size_in = '0;
               res_status_in = STATUS_OK;
               if (command_type'(req_tuser[1:0]) == CMD_PUT) begin
                  if (free_count_ff == '0) begin
                     res_status_in = STATUS_FULL;
                     state_in      = S_DONE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_idx   = free_head_ff;
                     state_in = S_PUT;
                  end
               end else if (count_ff[qv] == '0) begin
                  priority case (command_type'(req_tuser[1:0]))
                     CMD_GET:    res_status_in = STATUS_EMPTY;
                     CMD_REMOVE: res_status_in = STATUS_NOT_FOUND;
                     default:    res_status_in = STATUS_OK;
                  endcase
                  state_in = S_DONE;
               end else begin
                  left_in  = (command_type'(req_tuser[1:0]) == CMD_GET) ?
                             CNT_W'(1) : count_ff[qv];
                  cur_in   = head_ff[qv];
                  rd_en    = 1'b1;
                  rd_idx   = head_ff[qv];
                  state_in = S_EV;
               end
            end
         end

         // link the popped free entry into the queue
         S_PUT: begin
            free_head_in  = next_q_ff;
            free_count_in = free_count_ff - 1'b1;
            data_we       = 1'b1;
            data_wa       = free_head_ff;
            if (count_ff[q_ff] == '0) begin
               head_in[q_ff] = free_head_ff;
               tail_in[q_ff] = free_head_ff;
            end else if (lifo_ff) begin
               nx_we = 1'b1;
               nx_wa = free_head_ff;
               nx_wd = head_ff[q_ff];
               pv_we = 1'b1;
               pv_wa = head_ff[q_ff];
               pv_wd = free_head_ff;
               head_in[q_ff] = free_head_ff;
            end else begin
               pv_we = 1'b1;
               pv_wa = free_head_ff;
               pv_wd = tail_ff[q_ff];
               nx_we = 1'b1;
               nx_wa = tail_ff[q_ff];
               nx_wd = free_head_ff;
               tail_in[q_ff] = free_head_ff;
            end
            count_in[q_ff] = count_ff[q_ff] + 1'b1;
            res_status_in  = STATUS_OK;
            state_in       = S_DONE;
         end

         // read the next entry of the walk
         S_RD: begin
            rd_en    = 1'b1;
            rd_idx   = cur_ff;
            state_in = S_EV;
         end

         // examine one entry and unlink it on a match
         S_EV: begin
            nxt_in = n;
            if (match) begin
               found_in = 1'b1;
               if (cmd_ff == CMD_GET) begin
                  res_addr_in = addr_q_ff;
                  res_size_in = len_q_ff;
               end
               if (is_head) begin
                  head_in[q_ff] = n;
               end else begin
                  nx_we = 1'b1;
                  nx_wa = p;
                  nx_wd = n;
               end
               if (is_tail) begin
                  tail_in[q_ff] = p;
               end else begin
                  pv_we = 1'b1;
                  pv_wa = n;
                  pv_wd = p;
               end
               if (count_ff[q_ff] != '0) begin
                  count_in[q_ff] = count_ff[q_ff] - 1'b1;
               end
               if (is_head) begin
                  // head entry: push on the free list now
                  nx_we        = 1'b1;
                  nx_wa        = e;
                  nx_wd        = free_head_ff;
                  free_head_in = e;
                  if (free_count_ff < CNT_W'(POOL_ENTRIES)) begin
                     free_count_in = free_count_ff + 1'b1;
                  end
                  advance = 1'b1;
               end else begin
                  do_free = 1'b1;
               end
            end else begin
               advance = 1'b1;
            end
            if (do_free) begin
               state_in = S_FREE;
            end
         end

         // push a non-head entry on the free list
         S_FREE: begin
            nx_we        = 1'b1;
            nx_wa        = e;
            nx_wd        = free_head_ff;
            free_head_in = e;
            if (free_count_ff < CNT_W'(POOL_ENTRIES)) begin
               free_count_in = free_count_ff + 1'b1;
            end
            advance = 1'b1;
         end

         // hand the result to the response register
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_size_in   = res_size_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // step the walk to the following entry
      if (advance) begin
         left_in = left_dec;
         cur_in  = (state_ff == S_EV) ? n : nxt_ff;
         if (left_dec == '0) begin
            if (cmd_ff == CMD_REMOVE && !found_in) begin
               res_status_in = STATUS_NOT_FOUND;
            end else begin
               res_status_in = STATUS_OK;
            end
            state_in = S_DONE;
         end else begin
            state_in = S_RD;
         end
      end
   end

   // outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_size_ff, rsp_addr_ff};

endmodule

[rtl/mqsp_checker.sv]
// ----------------------------------------------------------------------------
// mqsp_checker
// Port-level checks for the message queue shared pool, bound to the top level.
// ----------------------------------------------------------------------------
module mqsp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [mqsp_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [mqsp_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mqsp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [mqsp_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import mqsp_pkg::*;

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // only a good get carries data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata == '0)
      else $error("error response with non-zero data");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // one command at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // a response is raised only after a busy cycle
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response raised while idle");

endmodule

bind message_queue_shared_pool mqsp_checker u_mqsp_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives put, get, remove and flush commands into the shared pool message
// queues and checks every response against a behavioural model of the
// linked lists and the free pool, under varying back-pressure.
// ----------------------------------------------------------------------------
module testbench;
   import mqsp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   // expected response of one transaction
   typedef struct packed {
      status_type  status;
      logic [31:0] address;
      logic [31:0] size;
   } response_type;

   response_type expected_responses[$];
   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int response_count = 0;
   int command_seen[4] = '{0, 0, 0, 0};
   int status_seen[4] = '{0, 0, 0, 0};

   // model state: one doubly linked list per queue, plus a free list
   logic [31:0] pool_address[POOL_ENTRIES];
   logic [31:0] pool_size[POOL_ENTRIES];
   int pool_next[POOL_ENTRIES];
   int pool_prev[POOL_ENTRIES];
   int list_head[NUM_QUEUES];
   int list_tail[NUM_QUEUES];
   int list_len[NUM_QUEUES];
   int free_top;
   int free_len;

   message_queue_shared_pool i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock generation
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // model reset
   task automatic pool_reset();
      for (int i = 0; i < POOL_ENTRIES; i++) begin
         pool_next[i] = (i + 1) % POOL_ENTRIES;
         pool_prev[i] = 0;
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
         list_head[i] = 0;
         list_tail[i] = 0;
         list_len[i] = 0;
      end
      free_top = 0;
      free_len = POOL_ENTRIES;
   endtask

   // unlink one entry from a queue and push it on the free list
   task automatic release_to_pool(input int q, input int e);
      int p;
      int n;
      p = pool_prev[e];
      n = pool_next[e];
      if (e == list_head[q]) list_head[q] = n;
      else pool_next[p] = n;
      if (e == list_tail[q]) list_tail[q] = p;
      else pool_prev[n] = p;
      if (list_len[q] > 0) list_len[q]--;
      pool_next[e] = free_top;
      free_top = e;
      if (free_len < POOL_ENTRIES) free_len++;
   endtask

   // apply one command to the model and return its response
   task automatic predict_response(input command_type cmd, input logic [1:0] qid,
                                   input logic [31:0] addr, input logic [31:0] size,
                                   input logic lifo, output response_type r);
      int q;
      int e;
      int n;
      int left;
      bit found;
      q = qid % NUM_QUEUES;
      r = '{STATUS_OK, 32'd0, 32'd0};
      case (cmd)
         CMD_PUT: begin
            if (free_len == 0) begin
               r.status = STATUS_FULL;
            end else begin
               e = free_top;
               free_top = pool_next[e];
               free_len--;
               pool_address[e] = addr;
               pool_size[e] = size;
               if (list_len[q] == 0) begin
                  list_head[q] = e;
                  list_tail[q] = e;
               end else if (lifo) begin
                  pool_next[e] = list_head[q];
                  pool_prev[list_head[q]] = e;
                  list_head[q] = e;
               end else begin
                  pool_prev[e] = list_tail[q];
                  pool_next[list_tail[q]] = e;
                  list_tail[q] = e;
               end
               list_len[q]++;
            end
         end
         CMD_GET: begin
            if (list_len[q] == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               e = list_head[q];
               r.address = pool_address[e];
               r.size = pool_size[e];
               release_to_pool(q, e);
            end
         end
         default: begin
            left = list_len[q];
            e = list_head[q];
            found = 0;
            while (left > 0) begin
               n = pool_next[e];
               if (cmd == CMD_FLUSH || pool_address[e] == addr) begin
                  found = 1;
                  release_to_pool(q, e);
               end
               e = n;
               left--;
            end
            if (cmd == CMD_REMOVE && !found) r.status = STATUS_NOT_FOUND;
         end
      endcase
   endtask

   // send one command transaction and queue its expected response
   // (valid stays up after acceptance until the next send or idle cycle)
   task automatic send_command(input command_type cmd, input logic [1:0] qid,
                               input logic [31:0] addr, input logic [31:0] size,
                               input logic lifo);
      response_type r;
      while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      predict_response(cmd, qid, addr, size, lifo, r);
      expected_responses.push_back(r);
      command_seen[cmd]++;
      req_tvalid <= 1'b1;
      req_tdata <= {size, addr};
      req_tuser <= {lifo, qid, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // hold off until every response is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // address mostly drawn from a small set so removes find matches
   function automatic logic [31:0] pick_address();
      case ($urandom_range(3, 0))
         0: return 32'hFFFF_FFFF;
         1: return $urandom();
         default: return 32'h1000 + $urandom_range(7, 0);
      endcase
   endfunction

   // response checker and receiver stall
   always @(posedge clock) begin
      response_type e;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_responses.size() == 0) begin
               $error("unexpected response transaction");
               error_count++;
            end else begin
               e = expected_responses.pop_front();
               response_count++;
               status_seen[rsp_tuser]++;
               if (rsp_tuser !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[31:0] !== e.address) begin
                  $error("got_address: expected %h, got %h", e.address, rsp_tdata[31:0]);
                  error_count++;
               end
               if (rsp_tdata[63:32] !== e.size) begin
                  $error("got_size: expected %h, got %h", e.size, rsp_tdata[63:32]);
                  error_count++;
               end
            end
         end
         rsp_tready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
      end
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // directed: field extremes, every command and each corner case
   task automatic test_directed();
      send_command(CMD_GET, 2'd0, 32'd0, 32'd0, 1'b0);
      send_command(CMD_REMOVE, 2'd1, 32'd5, 32'd0, 1'b0);
      send_command(CMD_FLUSH, 2'd2, 32'd0, 32'd0, 1'b0);
      send_command(CMD_PUT, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_command(CMD_PUT, 2'd3, 32'd0, 32'd0, 1'b1);
      send_command(CMD_PUT, 2'd3, 32'h1234_5678, 32'h8765_4321, 1'b0);
      send_command(CMD_GET, 2'd3, 32'd0, 32'd0, 1'b0);
      send_command(CMD_REMOVE, 2'd3, 32'h1234_5678, 32'd0, 1'b0);
      send_command(CMD_REMOVE, 2'd3, 32'h1234_5678, 32'd0, 1'b0);
      send_command(CMD_GET, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_command(CMD_GET, 2'd3, 32'd0, 32'd0, 1'b0);
      // exhaust the pool, then overflow it
      for (int i = 0; i < POOL_ENTRIES + 2; i++)
         send_command(CMD_PUT, 2'(i), 32'h10 + (i % 3), 32'(i), 1'(i));
      send_command(CMD_REMOVE, 2'd1, 32'h10, 32'd0, 1'b0);
      send_command(CMD_FLUSH, 2'd0, 32'd0, 32'd0, 1'b0);
   endtask

   // random mix of puts, gets, removes and flushes
   task automatic test_random(input int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99, 0);
         if (r < 45)
            send_command(CMD_PUT, 2'($urandom()), pick_address(), $urandom(),
                         1'($urandom()));
         else if (r < 80)
            send_command(CMD_GET, 2'($urandom()), $urandom(), $urandom(), 1'($urandom()));
         else if (r < 94)
            send_command(CMD_REMOVE, 2'($urandom()), pick_address(), $urandom(),
                         1'($urandom()));
         else
            send_command(CMD_FLUSH, 2'($urandom()), $urandom(), $urandom(),
                         1'($urandom()));
      end
   endtask

   // phases of sender idling and receiver stalling
   task automatic test_idling_phases();
      int idle_set[4] = '{0, 45, 0, 22};
      int stall_set[4] = '{0, 0, 45, 22};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_set[p];
         recv_stall_pct = stall_set[p];
         test_random(360);
         if (p == 1) wait_drained();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      pool_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_drained();
      test_idling_phases();
      wait_drained();
      repeat (80) @(posedge clock);
      $display("covered %0d responses: put %0d, get %0d, remove %0d, flush %0d",
               response_count, command_seen[0], command_seen[1], command_seen[2],
               command_seen[3]);
      $display("status ok %0d, empty %0d, full %0d, not found %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (error_count == 0 && expected_responses.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
